/* sv/u8sr_pkg.sv */
`timescale 1ns / 1ps

package u8sr_pkg;

    localparam int unsigned SCALAR_W = 21;

    // Replacement character U+25A1, emitted as E2 96 A1
    localparam logic [SCALAR_W-1:0] REPL_SCALAR = 21'h0025A1;

    // Lead classes, as sequence lengths
    localparam logic [2:0] LEN_BAD = 3'd0;
    localparam logic [2:0] LEN_1   = 3'd1;
    localparam logic [2:0] LEN_2   = 3'd2;
    localparam logic [2:0] LEN_3   = 3'd3;
    localparam logic [2:0] LEN_4   = 3'd4;

    // Encoder prefixes and range limits
    localparam logic [7:0] PFX_CONT = 8'h80;
    localparam logic [7:0] PFX_2    = 8'hC0;
    localparam logic [7:0] PFX_3    = 8'hE0;
    localparam logic [7:0] PFX_4    = 8'hF0;
    localparam logic [SCALAR_W-1:0] MAX_1 = 21'h00007F;
    localparam logic [SCALAR_W-1:0] MAX_2 = 21'h0007FF;
    localparam logic [SCALAR_W-1:0] MAX_3 = 21'h00FFFF;

    // One decoded scalar on its way to the encoder
    typedef struct packed {
        logic [SCALAR_W-1:0] scalar;
        logic                run_end;   // last scalar caused by its input byte
        logic                text_end;  // last scalar of the whole text
    } u8sr_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } u8sr_qstat_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            len = LEN_BAD;
            if (b inside {[8'h00:8'h7F]})
                len = LEN_1;
            else if (b inside {[8'hC2:8'hDF]})
                len = LEN_2;
            else if (b inside {[8'hE0:8'hEF]})
                len = LEN_3;
            else if (b inside {[8'hF0:8'hF4]})
                len = LEN_4;
            return len;
        end
    endfunction

endpackage

/* sv/utf8_sanitize_reencode.sv */
`timescale 1ns / 1ps
// Path: input is registered in byte buffer, queue, encoder byte reg, output register.
// Throughput: the judge takes no new input beat until it has made every sequence
//   decision it allows (1 normally, up to 4 when bytes are replayed); the encoder
//   sends one output beat per cycle unless stalled, 1 to 4 beats per decoded scalar.
// Reset: asynchronous, active low; clears counts, pointers and valids. Byte buffers
//   and the queue contents are not reset and are never read before being written.
module utf8_sanitize_reencode
    import u8sr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // text_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // [0] text_end
);

    // Front: buffer bytes, judge each sequence, hand one scalar per decision.
    // Queue: lets the judge run ahead while the encoder drains multi-byte output.
    // Back: re-encode each scalar in minimal form, one beat per cycle unless the output stalls.

    logic        q_push;
    u8sr_item_t  q_push_item;
    logic        q_pop;
    u8sr_item_t  q_head;
    u8sr_qstat_t q_stat;

    u8sr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .push      (q_push),
        .push_item (q_push_item),
        .q_full    (q_stat.full)
    );

    u8sr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .head_item (q_head),
        .stat      (q_stat)
    );

    u8sr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (q_head),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTH
    // End of text is always the last beat of its input byte's run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("text_end without run_last");

    // Judge never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    // Encoder never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // A scalar that ends the text also ends its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_push_item.text_end) |-> q_push_item.run_end)
        else $error("text_end scalar not marked run_end");
`endif

endmodule

/* sv/u8sr_front.sv */
`timescale 1ns / 1ps

// Byte buffer and sequence judge: one loop step per cycle while the queue is not full, at most one scalar out per step.
module u8sr_front
    import u8sr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    output logic       push,
    output u8sr_item_t push_item,
    input  logic       q_full
);

    logic [7:0] pend_reg [4];
    logic [7:0] pend_next [4];
    logic [7:0] shifted [4];
    logic [2:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic       last_reg, last_next;

    logic [7:0]          b0;
    logic [2:0]          len;
    logic [2:0]          len_n;
    logic [2:0]          drop;
    logic [2:0]          cnt_after;
    logic                emit, stop, clear, good, more, accept, advance;
    logic [SCALAR_W-1:0] scalar;
    logic [SCALAR_W-1:0] decoded;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && !busy_reg;

    always_comb
    begin
        b0   = pend_reg[0];
        len  = lead_len(b0);
        good = ((len < LEN_2) || (pend_reg[1][7:6] == 2'b10))
            && ((len < LEN_3) || (pend_reg[2][7:6] == 2'b10))
            && ((len < LEN_4) || (pend_reg[3][7:6] == 2'b10));

        case (len)
            LEN_2:   decoded = {10'd0, b0[4:0], pend_reg[1][5:0]};
            LEN_3:   decoded = {5'd0, b0[3:0], pend_reg[1][5:0], pend_reg[2][5:0]};
            LEN_4:   decoded = {b0[2:0], pend_reg[1][5:0], pend_reg[2][5:0],
                                pend_reg[3][5:0]};
            default: decoded = {13'd0, b0};
        endcase

        emit   = 1'b0;
        stop   = 1'b0;
        clear  = 1'b0;
        drop   = 3'd0;
        scalar = REPL_SCALAR;
        if (cnt_reg == 3'd0)
        begin
            stop = 1'b1;
        end
        else if (len == LEN_BAD)
        begin
            emit = 1'b1;
            drop = 3'd1;
        end
        else if (cnt_reg < len)
        begin
            // incomplete: replace at end of text, otherwise wait for more bytes
            if (last_reg)
            begin
                emit  = 1'b1;
                clear = 1'b1;
            end
            else
            begin
                stop = 1'b1;
            end
        end
        else if (good)
        begin
            emit   = 1'b1;
            drop   = len;
            scalar = decoded;
        end
        else
        begin
            // bad continuation: drop the lead, replay the rest
            emit = 1'b1;
            drop = 3'd1;
        end

        case (drop)
            3'd1:    shifted = '{pend_reg[1], pend_reg[2], pend_reg[3], pend_reg[3]};
            3'd2:    shifted = '{pend_reg[2], pend_reg[3], pend_reg[3], pend_reg[3]};
            3'd3:    shifted = '{pend_reg[3], pend_reg[3], pend_reg[3], pend_reg[3]};
            default: shifted = pend_reg;
        endcase

        cnt_after = clear ? 3'd0 : (cnt_reg - drop);
        len_n     = lead_len(shifted[0]);
        more      = (cnt_after != 3'd0)
                 && ((len_n == LEN_BAD) || (cnt_after >= len_n) || last_reg);

        advance = busy_reg && !stop && !q_full;
        push    = busy_reg && emit && !q_full;

        push_item.scalar   = scalar;
        push_item.run_end  = !more;
        push_item.text_end = !more && last_reg;

        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        last_next = last_reg;
        if (accept)
        begin
            pend_next[cnt_reg[1:0]] = s_tdata;
            cnt_next  = cnt_reg + 3'd1;
            busy_next = 1'b1;
            last_next = s_tlast;
        end
        else if (busy_reg && stop)
        begin
            busy_next = 1'b0;
        end
        else if (advance)
        begin
            pend_next = shifted;
            cnt_next  = cnt_after;
            busy_next = more;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

/* sv/u8sr_queue.sv */
`timescale 1ns / 1ps

// Small FIFO of decoded scalars between judge and encoder.
module u8sr_queue
    import u8sr_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  u8sr_item_t  push_item,
    input  logic        pop,
    output u8sr_item_t  head_item,
    output u8sr_qstat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    u8sr_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == CNT_FULL);
    assign stat.empty = (cnt_reg == '0);
    assign head_item  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + PTR_W'(1);
        if (pop)
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

endmodule

/* sv/u8sr_back.sv */
`timescale 1ns / 1ps

// Minimal-form encoder: one scalar in, one to four bytes out through an output register.
module u8sr_back
    import u8sr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  u8sr_item_t  head_item,
    input  u8sr_qstat_t q_stat,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    logic [7:0] byte_reg [4];
    logic [7:0] byte_next [4];
    logic [7:0] enc [4];
    logic [2:0] rem_reg, rem_next;
    logic [2:0] enc_n;
    logic       fin_reg, fin_next;
    logic       tend_reg, tend_next;
    logic       mv_reg, mv_next;
    logic [7:0] md_reg, md_next;
    logic       ml_reg, ml_next;
    logic       mu_reg, mu_next;
    logic       out_free, adv, seq_free;
    logic [SCALAR_W-1:0] s;

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
    assign m_tuser  = mu_reg;

    always_comb
    begin
        s = head_item.scalar;
        if (s <= MAX_1)
        begin
            enc_n = LEN_1;
            enc   = '{s[7:0], 8'h00, 8'h00, 8'h00};
        end
        else if (s <= MAX_2)
        begin
            enc_n = LEN_2;
            enc   = '{PFX_2 | {3'd0, s[10:6]}, PFX_CONT | {2'd0, s[5:0]}, 8'h00, 8'h00};
        end
        else if (s <= MAX_3)
        begin
            enc_n = LEN_3;
            enc   = '{PFX_3 | {4'd0, s[15:12]}, PFX_CONT | {2'd0, s[11:6]},
                      PFX_CONT | {2'd0, s[5:0]}, 8'h00};
        end
        else
        begin
            enc_n = LEN_4;
            enc   = '{PFX_4 | {5'd0, s[20:18]}, PFX_CONT | {2'd0, s[17:12]},
                      PFX_CONT | {2'd0, s[11:6]}, PFX_CONT | {2'd0, s[5:0]}};
        end

        out_free = !mv_reg || m_tready;
        adv      = (rem_reg != 3'd0) && out_free;
        seq_free = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && adv);
        pop      = seq_free && !q_stat.empty;

        byte_next = byte_reg;
        rem_next  = rem_reg;
        fin_next  = fin_reg;
        tend_next = tend_reg;
        mv_next   = mv_reg && !m_tready;
        md_next   = md_reg;
        ml_next   = ml_reg;
        mu_next   = mu_reg;

        if (adv)
        begin
            mv_next   = 1'b1;
            md_next   = byte_reg[0];
            ml_next   = (rem_reg == 3'd1) && fin_reg;
            mu_next   = (rem_reg == 3'd1) && tend_reg;
            byte_next = '{byte_reg[1], byte_reg[2], byte_reg[3], byte_reg[3]};
            rem_next  = rem_reg - 3'd1;
        end
        if (pop)
        begin
            byte_next = enc;
            rem_next  = enc_n;
            fin_next  = head_item.run_end;
            tend_next = head_item.text_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
            mv_reg  <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            mv_reg  <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        fin_reg  <= fin_next;
        tend_reg <= tend_next;
        md_reg   <= md_next;
        ml_reg   <= ml_next;
        mu_reg   <= mu_next;
    end

endmodule

/* verif/tb_utf8_sanitize_reencode.sv */
`timescale 1ns / 1ps

module tb_utf8_sanitize_reencode;

    import u8sr_pkg::*;

    // One output beat as the block should present it
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       text_end;
    } out_beat_t;

    // Scoreboard: mirrors the sequence buffer of the block, turns every
    // accepted input beat into the output beats it must cause, and checks
    // the output stream against them in order.
    class utf8_scoreboard;
        out_beat_t   expected_bytes[$];
        out_beat_t   step_bytes[$];
        logic [7:0]  held_bytes[4];
        int unsigned held_count;
        int unsigned mismatches;

        function new();
            held_count = 0;
            mismatches = 0;
        endfunction

        // Sequence length implied by a lead byte, or LEN_BAD
        function logic [2:0] seq_length(logic [7:0] b);
            if (b <= 8'h7F)
                return LEN_1;
            if (b >= 8'hC2 && b <= 8'hDF)
                return LEN_2;
            if (b >= 8'hE0 && b <= 8'hEF)
                return LEN_3;
            if (b >= 8'hF0 && b <= 8'hF4)
                return LEN_4;
            return LEN_BAD;
        endfunction

        function void push_byte(logic [7:0] b);
            out_beat_t e;
            e.data     = b;
            e.run_last = 1'b0;
            e.text_end = 1'b0;
            step_bytes = {step_bytes, e};
        endfunction

        // Minimal-form UTF-8 encoding of one scalar
        function void encode_scalar(logic [SCALAR_W-1:0] s);
            if (s <= MAX_1)
            begin
                push_byte(s[7:0]);
            end
            else if (s <= MAX_2)
            begin
                push_byte(PFX_2 | {3'b000, s[10:6]});
                push_byte(PFX_CONT | {2'b00, s[5:0]});
            end
            else if (s <= MAX_3)
            begin
                push_byte(PFX_3 | {4'b0000, s[15:12]});
                push_byte(PFX_CONT | {2'b00, s[11:6]});
                push_byte(PFX_CONT | {2'b00, s[5:0]});
            end
            else
            begin
                push_byte(PFX_4 | {5'b00000, s[20:18]});
                push_byte(PFX_CONT | {2'b00, s[17:12]});
                push_byte(PFX_CONT | {2'b00, s[11:6]});
                push_byte(PFX_CONT | {2'b00, s[5:0]});
            end
        endfunction

        function void drop_front(int unsigned k);
            int unsigned i;
            if (k >= held_count)
            begin
                held_count = 0;
                return;
            end
            for (i = 0; i < held_count - k; i++)
                held_bytes[i] = held_bytes[i + k];
            held_count = held_count - k;
        endfunction

        // Note one accepted input beat and queue the output it causes
        function void sanitize_byte(logic [7:0] b, logic last);
            logic [2:0]          len;
            logic [SCALAR_W-1:0] v;
            logic [7:0]          c;
            bit                  bad;
            bit                  waiting;
            int unsigned         i;
            step_bytes.delete();
            held_bytes[held_count] = b;
            held_count++;
            waiting = 1'b0;
            while (held_count > 0 && !waiting)
            begin
                len = seq_length(held_bytes[0]);
                if (len == LEN_BAD)
                begin
                    encode_scalar(REPL_SCALAR);
                    drop_front(1);
                end
                else if (held_count < len)
                begin
                    // cut short by the end of the text: one replacement for all
                    if (last)
                    begin
                        encode_scalar(REPL_SCALAR);
                        held_count = 0;
                    end
                    waiting = 1'b1;
                end
                else
                begin
                    case (len)
                        LEN_1:   v = {13'd0, held_bytes[0]};
                        LEN_2:   v = {16'd0, held_bytes[0][4:0]};
                        LEN_3:   v = {17'd0, held_bytes[0][3:0]};
                        default: v = {18'd0, held_bytes[0][2:0]};
                    endcase
                    bad = 1'b0;
                    for (i = 1; i < len && !bad; i++)
                    begin
                        c = held_bytes[i];
                        if (c[7:6] != 2'b10)
                            bad = 1'b1;
                        else
                            v = {v[SCALAR_W-7:0], c[5:0]};
                    end
                    // a bad continuation drops only the lead; the rest is replayed
                    if (bad)
                    begin
                        encode_scalar(REPL_SCALAR);
                        drop_front(1);
                    end
                    else
                    begin
                        encode_scalar(v);
                        drop_front(len);
                    end
                end
            end
            if (step_bytes.size() > 0)
            begin
                step_bytes[step_bytes.size() - 1].run_last = 1'b1;
                step_bytes[step_bytes.size() - 1].text_end = last;
            end
            foreach (step_bytes[k])
                expected_bytes = {expected_bytes, step_bytes[k]};
        endfunction

        function void check_result(logic [7:0] b, logic rl, logic te);
            out_beat_t e;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat: data %h last %b user %b", b, rl, te);
                return;
            end
            e = expected_bytes.pop_front();
            if (e.data !== b || e.run_last !== rl || e.text_end !== te)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("output beat: expected data %h last %b user %b, got %h %b %b",
                             e.data, e.run_last, e.text_end, b, rl, te);
            end
        endfunction

        function int unsigned outstanding();
            return expected_bytes.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    utf8_scoreboard sb;

    // Idle-free stretches on each side
    bit          tx_calm;
    bit          rx_calm;
    int unsigned rx_beats;

    // Directed beats: bit 8 is text_last, bits 7:0 the byte
    logic [8:0]  directed_beats [0:24];
    // Bytes of the random text being built
    logic [7:0]  text_bytes[$];
    int unsigned random_items;

    utf8_sanitize_reencode dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [7:0] in_byte
        .s_tlast  (s_tlast),     // text_last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // [7:0] out_byte
        .m_tlast  (m_tlast),     // run_last
        .m_tuser  (m_tuser)      // [0] text_end
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Monitor both handshakes with the values seen at the edge. An input beat
    // cannot show up at the output on the same edge, so note it first.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.sanitize_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast, m_tuser);
        end
    end

    // Offer one input beat after a random gap and hold it until accepted.
    // With no gap, tvalid stays high from the previous beat.
    task automatic send_beat(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Add one byte at the end of the text being built
    function automatic void append_text(logic [7:0] b);
        text_bytes = {text_bytes, b};
    endfunction

    // Append one character to the text: mostly well-formed sequences with
    // random content, some overlong, some noise, some broken sequences.
    function automatic void add_char();
        int unsigned r;
        int unsigned len;
        int unsigned k;
        int unsigned i;
        r = $urandom_range(0, 99);
        if (r < 22)
        begin
            append_text(8'($urandom_range(8'h00, 8'h7F)));
        end
        else if (r < 40)
        begin
            append_text(8'($urandom_range(8'hC2, 8'hDF)));
            append_text(cont_byte());
        end
        else if (r < 58)
        begin
            append_text(8'($urandom_range(8'hE0, 8'hEF)));
            append_text(cont_byte());
            append_text(cont_byte());
        end
        else if (r < 72)
        begin
            append_text(8'($urandom_range(8'hF0, 8'hF4)));
            append_text(cont_byte());
            append_text(cont_byte());
            append_text(cont_byte());
        end
        else if (r < 77)
        begin
            // overlong forms that shrink on re-encoding
            if ($urandom_range(0, 1))
            begin
                append_text(8'hE0);
                append_text(8'h80 | 8'($urandom_range(0, 31)));
            end
            else
            begin
                append_text(8'hF0);
                append_text(8'h80 | 8'($urandom_range(0, 15)));
                append_text(cont_byte());
            end
            append_text(cont_byte());
        end
        else if (r < 88)
        begin
            append_text(8'($urandom_range(0, 255)));
        end
        else
        begin
            // lead with too few continuations, then maybe a non-continuation
            len = $urandom_range(2, 4);
            case (len)
                2:       append_text(8'($urandom_range(8'hC2, 8'hDF)));
                3:       append_text(8'($urandom_range(8'hE0, 8'hEF)));
                default: append_text(8'($urandom_range(8'hF0, 8'hF4)));
            endcase
            k = $urandom_range(0, len - 2);
            for (i = 0; i < k; i++)
                append_text(cont_byte());
            if ($urandom_range(0, 1))
            begin
                if ($urandom_range(0, 1))
                    append_text(8'($urandom_range(8'h00, 8'h7F)));
                else
                    append_text(8'($urandom_range(8'hC0, 8'hFF)));
            end
        end
    endfunction

    // Hold the sender until every expected beat has come out
    task automatic wait_drained();
        while (sb.outstanding() > 0)
            @(posedge clk);
    endtask

    // Receiver: random stall per beat, calm stretches, and one long hold-off
    // so the block fills up and pushes back on its input.
    initial
    begin
        int unsigned stall;
        m_tready <= 1'b0;
        rx_calm  = 1'b0;
        rx_beats = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            rx_beats++;
            if (rx_beats % 40 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (rx_beats == 80)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int unsigned n;
        int unsigned i;
        sb       = new();
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        tx_calm  = 1'b0;
        random_items = 0;

        directed_beats = '{
            // ASCII extremes, the second one ending a text
            9'h000, 9'h17F,
            // two-byte minimum, overlong three- and four-byte zeros
            9'h0C2, 9'h080,
            9'h0E0, 9'h080, 9'h080,
            9'h0F0, 9'h080, 9'h080, 9'h080,
            // largest scalar an F4 lead allows, passed through
            9'h0F4, 9'h0BF, 9'h0BF, 9'h0BF,
            // surrogate, passed through
            9'h0ED, 9'h0A0, 9'h080,
            // bad leads
            9'h080, 9'h0F5, 9'h0FF,
            // chained bad continuations with replay, then a cut-short end:
            // four replacements from the final beat
            9'h0F0, 9'h0E0, 9'h0C2, 9'h1C2
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 25; i++)
            send_beat(directed_beats[i][7:0], directed_beats[i][8]);
        s_tvalid <= 1'b0;
        wait_drained();

        // Random texts; each ends on a beat with text_last set
        while (random_items < 240)
        begin
            text_bytes.delete();
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                add_char();
            tx_calm = ($urandom_range(0, 4) == 0);
            foreach (text_bytes[j])
                send_beat(text_bytes[j], j == text_bytes.size() - 1);
            random_items += text_bytes.size();
            // pause the sender once mid-run until everything is out
            if (random_items >= 120 && random_items < 120 + text_bytes.size())
            begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.outstanding() > 0)
        begin
            sb.mismatches++;
            $display("%0d expected output beats never arrived", sb.outstanding());
        end
        if (sb.mismatches == 0)
            $display("utf8_sanitize_reencode: match");
        else
            $display("utf8_sanitize_reencode: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("utf8_sanitize_reencode: mismatch");
        $finish;
    end

endmodule
